// ===== rtl/core/variable_length_message_ring_unit_defines.svh =====
// Assertion macros for the variable-length message ring unit.
`ifndef VARIABLE_LENGTH_MESSAGE_RING_UNIT_DEFINES_SVH
`define VARIABLE_LENGTH_MESSAGE_RING_UNIT_DEFINES_SVH

// Overlapping implication, checked on every rising clock edge out of reset.
`define VLMR_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define VLMR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/vlmr_pkg.sv =====
// Types, constants and helpers for the variable-length message ring unit.
`default_nettype none

package vlmr_pkg;

  localparam int RING_BYTES   = 4096;
  localparam int LINE_BYTES   = 64;
  localparam int HEADER_BYTES = 4;

  localparam int OFS_W      = $clog2(RING_BYTES);
  localparam int POS_W      = OFS_W + 1;
  localparam int LINE_W     = $clog2(LINE_BYTES);
  localparam int SLOT_W     = OFS_W - LINE_W;
  localparam int LINE_COUNT = RING_BYTES / LINE_BYTES;
  localparam int SIZE_W     = 12;
  localparam int STATUS_W   = 3;
  localparam int CALC_W     = ((POS_W > SIZE_W + 1) ? POS_W : SIZE_W + 1) + 1;

  localparam logic [SIZE_W-1:0] MAX_MSG_RESET = SIZE_W'(1024);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_INVALID  = 3'd1,
    STAT_NO_SPACE = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_CORRUPT  = 3'd4
  } status_e;

  // Header plus payload, rounded up to whole lines
  function automatic logic [CALC_W-1:0] line_round(input logic [SIZE_W-1:0] size);
    logic [CALC_W-1:0] n;
    n = CALC_W'(size) + CALC_W'(HEADER_BYTES + LINE_BYTES - 1);
    return n & ~CALC_W'(LINE_BYTES - 1);
  endfunction

  // Start of the next lap of the ring
  function automatic logic [POS_W-1:0] next_start(input logic [POS_W-1:0] pos);
    return {~pos[POS_W-1], {OFS_W{1'b0}}};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vlmr_req_if.sv =====
// Request channel: operation and message size.
`default_nettype none

interface vlmr_req_if
  import vlmr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [SIZE_W-1:0] msg_size;

  modport source (output valid, output operation, output msg_size, input ready);
  modport sink   (input valid, input operation, input msg_size, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vlmr_rsp_if.sv =====
// Response channel: status, message placement and ring occupancy.
`default_nettype none

interface vlmr_rsp_if
  import vlmr_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFS_W-1:0]    payload_offset;
  logic [SIZE_W-1:0]   payload_size;
  logic [POS_W-1:0]    used_bytes;
  logic                is_empty;
  logic                is_full;

  modport source (
    output valid, output status, output payload_offset, output payload_size,
    output used_bytes, output is_empty, output is_full, input ready
  );
  modport sink (
    input valid, input status, input payload_offset, input payload_size,
    input used_bytes, input is_empty, input is_full, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/variable_length_message_ring_unit.sv =====
// Variable-length message ring unit: space management for push and pop of messages.
// Each request transfer registers a header read (S_IDLE), then the update commits and
// registers the result (S_EXEC); a new request is taken only once the update has
// committed. A waiting result lets the next request transfer but holds its update.
// Reset: write and read points clear, limit returns to 1024; the header memory is not
// cleared and needs no clearing pass.
`default_nettype none
`include "variable_length_message_ring_unit_defines.svh"

module variable_length_message_ring_unit
  import vlmr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [SIZE_W-1:0] cfg_wdata_i,
  vlmr_req_if.sink               req_i,
  vlmr_rsp_if.source             rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  localparam logic [CALC_W-1:0] RING_C = CALC_W'(RING_BYTES);
  localparam logic [CALC_W-1:0] LINE_C = CALC_W'(LINE_BYTES);
  localparam logic [CALC_W-1:0] HDR_C  = CALC_W'(HEADER_BYTES);

  state_e              state_q, state_d;
  logic                op_q;
  logic [SIZE_W-1:0]   size_q;
  logic [SIZE_W-1:0]   max_q;
  logic [POS_W-1:0]    wp_q, wp_d;
  logic [POS_W-1:0]    rp_q, rp_d;
  logic [SIZE_W-1:0]   slot0_q;
  logic [SIZE_W-1:0]   hdr_rd_q;
  logic [SIZE_W-1:0]   hdr_mem_q [LINE_COUNT];

  logic                rsp_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [OFS_W-1:0]    ofs_q;
  logic [SIZE_W-1:0]   psz_q;
  logic [POS_W-1:0]    used_q;
  logic                empty_q;
  logic                full_q;

  logic                accept;
  logic                commit;

  // update datapath
  status_e             status_d;
  logic [OFS_W-1:0]    ofs_d;
  logic [SIZE_W-1:0]   psz_d;
  logic [POS_W-1:0]    used_d;
  logic                full_d;
  logic [CALC_W-1:0]   need, span, u1, u2, avail1, avail2, room1, msum, thresh;
  logic [POS_W-1:0]    pad_pos, cur, nxt;
  logic [SIZE_W-1:0]   hdr1, hdr;
  logic                pop_go;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_wa;
  logic [SIZE_W-1:0]   mem_wd;
  logic                s0_we;
  logic [SIZE_W-1:0]   s0_wd;

  assign accept      = req_i.valid & req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign commit      = (state_q == S_EXEC) & (~rsp_valid_q | rsp_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    wp_d     = wp_q;
    rp_d     = rp_q;
    status_d = STAT_OK;
    ofs_d    = '0;
    psz_d    = '0;
    mem_we   = 1'b0;
    mem_wa   = wp_q[OFS_W-1:LINE_W];
    mem_wd   = '0;
    s0_we    = 1'b0;
    s0_wd    = '0;
    cur      = rp_q;
    nxt      = rp_q;
    hdr      = '0;
    span     = '0;
    pop_go   = 1'b0;

    need    = line_round(size_q);
    u1      = CALC_W'(POS_W'(wp_q - rp_q));
    avail1  = (u1 > RING_C) ? '0 : RING_C - u1;
    room1   = RING_C - CALC_W'(wp_q[OFS_W-1:0]);
    pad_pos = next_start(wp_q);
    u2      = CALC_W'(POS_W'(pad_pos - rp_q));
    avail2  = (u2 > RING_C) ? '0 : RING_C - u2;
    hdr1    = (rp_q[OFS_W-1:LINE_W] == '0) ? slot0_q : hdr_rd_q;

    if (op_q == OP_PUSH) begin
      if ((size_q == '0) || (size_q > max_q)) begin
        status_d = STAT_INVALID;
      end else if (avail1 <= need + LINE_C) begin
        status_d = STAT_NO_SPACE;
      end else if (room1 < need) begin
        // padding header, then retry from the start of the ring
        if (wp_q[OFS_W-1:LINE_W] == '0) begin
          s0_we = 1'b1;
        end else begin
          mem_we = 1'b1;
        end
        wp_d = pad_pos;
        if (avail2 <= need + LINE_C) begin
          status_d = STAT_NO_SPACE;
        end else begin
          s0_we = 1'b1;
          s0_wd = size_q;
          ofs_d = OFS_W'(HEADER_BYTES);
          psz_d = size_q;
          wp_d  = pad_pos + need[POS_W-1:0];
        end
      end else begin
        if (wp_q[OFS_W-1:LINE_W] == '0) begin
          s0_we = 1'b1;
          s0_wd = size_q;
        end else begin
          mem_we = 1'b1;
          mem_wd = size_q;
        end
        ofs_d = wp_q[OFS_W-1:0] + OFS_W'(HEADER_BYTES);
        psz_d = size_q;
        wp_d  = wp_q + need[POS_W-1:0];
      end
    end else begin
      if (rp_q == wp_q) begin
        status_d = STAT_EMPTY;
      end else begin
        pop_go = 1'b1;
        hdr    = hdr1;
        if (hdr1 == '0) begin
          cur = next_start(rp_q);
          if (cur == wp_q) begin
            rp_d     = cur;
            status_d = STAT_EMPTY;
            pop_go   = 1'b0;
          end else begin
            hdr = slot0_q;
          end
        end
        if (pop_go) begin
          if (hdr > max_q) begin
            rp_d     = cur;
            status_d = STAT_CORRUPT;
          end else begin
            ofs_d = cur[OFS_W-1:0] + OFS_W'(HEADER_BYTES);
            psz_d = hdr;
            span  = line_round(hdr);
            nxt   = cur + span[POS_W-1:0];
            if (CALC_W'(nxt[OFS_W-1:0]) + HDR_C > RING_C) begin
              nxt = next_start(nxt);
            end
            rp_d = nxt;
          end
        end
      end
    end

    used_d = wp_d - rp_d;
    msum   = CALC_W'(max_q) + HDR_C;
    thresh = (msum >= RING_C) ? '0 : RING_C - msum;
    full_d = (CALC_W'(used_d) >= thresh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_q       <= MAX_MSG_RESET;
      wp_q        <= '0;
      rp_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (commit) begin
        wp_q        <= wp_d;
        rp_q        <= rp_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.operation;
      size_q <= req_i.msg_size;
    end
    if (commit) begin
      status_q <= status_d;
      ofs_q    <= ofs_d;
      psz_q    <= psz_d;
      used_q   <= used_d;
      empty_q  <= (rp_d == wp_d);
      full_q   <= full_d;
    end
    if (commit && s0_we) begin
      slot0_q <= s0_wd;
    end
  end

  // header memory; line zero lives in slot0_q
  always_ff @(posedge clk_i) begin
    if (commit && mem_we) begin
      hdr_mem_q[mem_wa] <= mem_wd;
    end
    if (accept) begin
      hdr_rd_q <= hdr_mem_q[rp_q[OFS_W-1:LINE_W]];
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.payload_offset = ofs_q;
  assign rsp_o.payload_size   = psz_q;
  assign rsp_o.used_bytes     = used_q;
  assign rsp_o.is_empty       = empty_q;
  assign rsp_o.is_full        = full_q;

  `VLMR_ASSERT_NEXT(a_req_starts_update, accept, state_q == S_EXEC, "transfer did not start update")
  `VLMR_ASSERT_NEXT(a_update_gives_rsp, commit, rsp_o.valid, "update gave no response")
  `VLMR_ASSERT_NOW(a_fail_no_payload, rsp_o.valid && (rsp_o.status != STAT_OK),
    (rsp_o.payload_offset == '0) && (rsp_o.payload_size == '0), "failed op with payload")
  `VLMR_ASSERT_NEXT(a_points_hold, !commit, $stable(wp_q) && $stable(rp_q),
    "ring points moved outside update")

endmodule

`default_nettype wire

// ===== tb/sv/vlmr_ring_checker.sv =====
// Checker for the message ring unit: predicts every result from accepted requests and compares.
`timescale 1ns / 1ps

module vlmr_ring_checker
  import vlmr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  vlmr_req_if               req_i,
  vlmr_rsp_if               rsp_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    status_e           status;
    logic [OFS_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic [POS_W-1:0]  used;
    logic              empty;
    logic              full;
  } ring_result_t;

  logic [POS_W-1:0]  wr_pos;
  logic [POS_W-1:0]  rd_pos;
  logic [SIZE_W-1:0] size_limit;
  logic [SIZE_W-1:0] hdr_mem [LINE_COUNT];
  ring_result_t      ring_result_q [$];

  // Header plus payload in whole lines
  function automatic int span_of(input logic [SIZE_W-1:0] size);
    return ((int'(size) + HEADER_BYTES + LINE_BYTES - 1) / LINE_BYTES) * LINE_BYTES;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [POS_W-1:0] pos);
    return pos[OFS_W-1:LINE_W];
  endfunction

  function automatic logic [POS_W-1:0] lap_start(input logic [POS_W-1:0] pos);
    return pos + POS_W'(RING_BYTES - int'(pos[OFS_W-1:0]));
  endfunction

  task automatic predict_ring_op(input logic op, input logic [SIZE_W-1:0] size);
    ring_result_t      res;
    logic [POS_W-1:0]  cur;
    logic [POS_W-1:0]  occupied;
    logic [SIZE_W-1:0] hdr;
    int                need;
    int                avail;
    int                room;
    int                thresh;
    res = '0;
    if (op == OP_PUSH) begin
      if (size == '0 || size > size_limit) begin
        res.status = STAT_INVALID;
      end else begin
        need = span_of(size);
        res.status = STAT_NO_SPACE;
        for (int pass = 0; pass < 2; pass++) begin
          occupied = wr_pos - rd_pos;
          avail = (int'(occupied) > RING_BYTES) ? 0 : RING_BYTES - int'(occupied);
          room = RING_BYTES - int'(wr_pos[OFS_W-1:0]);
          if (avail <= need + LINE_BYTES) break;
          if (room < need) begin
            // padding header, then wrap to the start
            hdr_mem[slot_of(wr_pos)] = '0;
            wr_pos = lap_start(wr_pos);
            continue;
          end
          hdr_mem[slot_of(wr_pos)] = size;
          res.offset = wr_pos[OFS_W-1:0] + OFS_W'(HEADER_BYTES);
          res.size = size;
          wr_pos = wr_pos + POS_W'(need);
          res.status = STAT_OK;
          break;
        end
      end
    end else if (rd_pos == wr_pos) begin
      res.status = STAT_EMPTY;
    end else begin
      cur = rd_pos;
      hdr = hdr_mem[slot_of(cur)];
      if (hdr == '0) begin
        cur = lap_start(cur);
        if (cur != wr_pos) hdr = hdr_mem[slot_of(cur)];
      end
      if (cur == wr_pos) begin
        rd_pos = cur;
        res.status = STAT_EMPTY;
      end else if (hdr > size_limit) begin
        rd_pos = cur;
        res.status = STAT_CORRUPT;
      end else begin
        res.offset = cur[OFS_W-1:0] + OFS_W'(HEADER_BYTES);
        res.size = hdr;
        cur = cur + POS_W'(span_of(hdr));
        if (int'(cur[OFS_W-1:0]) + HEADER_BYTES > RING_BYTES) cur = lap_start(cur);
        rd_pos = cur;
        res.status = STAT_OK;
      end
    end
    res.used = wr_pos - rd_pos;
    res.empty = (wr_pos == rd_pos);
    if (int'(size_limit) + HEADER_BYTES >= RING_BYTES) thresh = 0;
    else thresh = RING_BYTES - int'(size_limit) - HEADER_BYTES;
    res.full = (int'(res.used) >= thresh);
    ring_result_q.push_back(res);
  endtask

  function automatic void compare_field(input string name, input logic [POS_W-1:0] expv,
                                        input logic [POS_W-1:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, actual %0d", name, expv, actv);
      fail_count_o++;
    end
  endfunction

  task automatic check_ring_result();
    ring_result_t exp_res;
    if (ring_result_q.size() == 0) begin
      $error("result transfer with no request outstanding");
      fail_count_o++;
    end else begin
      exp_res = ring_result_q.pop_front();
      compare_field("status", POS_W'(exp_res.status), POS_W'(rsp_i.status));
      compare_field("payload_offset", POS_W'(exp_res.offset), POS_W'(rsp_i.payload_offset));
      compare_field("payload_size", POS_W'(exp_res.size), POS_W'(rsp_i.payload_size));
      compare_field("used_bytes", exp_res.used, rsp_i.used_bytes);
      compare_field("is_empty", POS_W'(exp_res.empty), POS_W'(rsp_i.is_empty));
      compare_field("is_full", POS_W'(exp_res.full), POS_W'(rsp_i.is_full));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos = '0;
      rd_pos = '0;
      size_limit = MAX_MSG_RESET;
      ring_result_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) size_limit = cfg_wdata_i;
      if (rsp_i.valid && rsp_i.ready) check_ring_result();
      if (req_i.valid && req_i.ready) predict_ring_op(req_i.operation, req_i.msg_size);
      pending_o = ring_result_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_variable_length_message_ring_unit.sv =====
// Testbench top for the message ring unit: request and limit stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module tb_variable_length_message_ring_unit;
  import vlmr_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 200;
  localparam int PHASE_COUNT  = 10;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [SIZE_W-1:0] cfg_wdata_i;
  logic [SIZE_W-1:0] cur_limit;
  int                fail_count;
  int                pending;
  int                stall_cycles = 0;
  int                burst_left = 0;
  int                hold_asked = 0;

  vlmr_req_if req_if ();
  vlmr_rsp_if rsp_if ();

  variable_length_message_ring_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  vlmr_ring_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we_i)
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[variable_length_message_ring_unit] ERROR");
        $finish;
      end
    end
  end

  // Sender: bursts of back-to-back requests with random gaps between them
  task automatic issue_request(input logic op, input logic [SIZE_W-1:0] size);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk_i);
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.msg_size  <= size;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain_ring_ops();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_limit(input logic [SIZE_W-1:0] value);
    drain_ring_ops();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_limit = value;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int pick;
    int lim;
    lim = int'(cur_limit);
    pick = $urandom_range(0, 99);
    if (pick < 3) return '0;
    if (pick < 6) return SIZE_W'($urandom_range(lim + 1, 4095));
    if (pick < 60) return SIZE_W'($urandom_range(1, (lim < 60) ? lim : 60));
    if (pick < 85) return SIZE_W'($urandom_range(1, (lim < 500) ? lim : 500));
    return SIZE_W'($urandom_range(1, lim));
  endfunction

  // Receiver: runs of its own stall patterns, plus a long hold when asked
  initial begin
    int mode;
    int run;
    int hold_seen;
    rsp_if.ready = 1'b0;
    hold_seen = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_seen != hold_asked) begin
        hold_seen++;
        @(negedge clk_i);
        rsp_if.ready <= 1'b0;
        for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        run = $urandom_range(5, 60);
        repeat (run) begin
          @(negedge clk_i);
          case (mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2: rsp_if.ready <= ($urandom_range(0, 7) != 0);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    int lim;
    int push_pct;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    req_if.valid     = 1'b0;
    req_if.operation = OP_PUSH;
    req_if.msg_size  = '0;
    cur_limit        = MAX_MSG_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty pop, bad sizes, fill with padding and wrap, corrupt headers
    issue_request(OP_POP, '0);
    issue_request(OP_PUSH, '0);
    issue_request(OP_PUSH, 12'hFFF);
    issue_request(OP_PUSH, cur_limit + 1'b1);
    issue_request(OP_PUSH, 12'd1);
    issue_request(OP_PUSH, cur_limit);
    repeat (4) issue_request(OP_PUSH, 12'd1000);
    repeat (6) issue_request(OP_POP, '0);
    write_limit(12'd4092);
    issue_request(OP_PUSH, 12'd4092);
    issue_request(OP_PUSH, 12'd2000);
    write_limit(12'd100);
    repeat (2) issue_request(OP_POP, '0);
    write_limit(12'd3);
    issue_request(OP_PUSH, 12'd3);
    issue_request(OP_POP, '0);
    write_limit(12'd4092);
    repeat (3) issue_request(OP_POP, '0);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: lim = 1;
        1: lim = 4092;
        2: lim = 3;
        3: lim = 1024;
        4: lim = 64;
        5: lim = 2047;
        6: lim = 4091;
        7: lim = 200;
        8: lim = 1;
        default: lim = $urandom_range(1, 4092);
      endcase
      write_limit(SIZE_W'(lim));
      push_pct = (phase % 3 == 0) ? 70 : ((phase % 3 == 1) ? 30 : 50);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 40 && (phase == 2 || phase == 6)) begin
          hold_asked++;
          burst_left = 80;
        end
        if ($urandom_range(1, 100) <= push_pct)
          issue_request(OP_PUSH, pick_size());
        else
          issue_request(OP_POP, SIZE_W'($urandom));
      end
    end

    drain_ring_ops();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("[variable_length_message_ring_unit] OK");
    else
      $display("[variable_length_message_ring_unit] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/vlmr_pkg.sv
rtl/core/vlmr_req_if.sv
rtl/core/vlmr_rsp_if.sv
rtl/core/variable_length_message_ring_unit.sv
tb/sv/vlmr_ring_checker.sv
tb/sv/tb_variable_length_message_ring_unit.sv
